FILE: rtl/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg: shared types and constants of the pulse/sawtooth synth
// Item and result structs, register decode keys and IRQ counter constants.
// ----------------------------------------------------------------------------
package pss_pkg;

    // item kinds
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // decode key: address nibble [15:12] then select lines one and zero
    localparam logic [5:0] KEY_P0_CTRL  = {4'h9, 2'd0};
    localparam logic [5:0] KEY_P0_LO    = {4'h9, 2'd1};
    localparam logic [5:0] KEY_P0_HI    = {4'h9, 2'd2};
    localparam logic [5:0] KEY_P1_CTRL  = {4'ha, 2'd0};
    localparam logic [5:0] KEY_P1_LO    = {4'ha, 2'd1};
    localparam logic [5:0] KEY_P1_HI    = {4'ha, 2'd2};
    localparam logic [5:0] KEY_SAW_RATE = {4'hb, 2'd0};
    localparam logic [5:0] KEY_SAW_LO   = {4'hb, 2'd1};
    localparam logic [5:0] KEY_SAW_HI   = {4'hb, 2'd2};
    localparam logic [5:0] KEY_IRQ_LAT  = {4'hf, 2'd0};
    localparam logic [5:0] KEY_IRQ_CTRL = {4'hf, 2'd1};
    localparam logic [5:0] KEY_IRQ_ACK  = {4'hf, 2'd2};

    // irq counter
    localparam logic signed [9:0] PRESCALE_STEP   = 10'sd3;
    localparam logic signed [9:0] PRESCALE_RELOAD = 10'sd341;
    localparam logic [7:0]        COUNT_MAX       = 8'hff;

    // sawtooth stage at which the accumulator restarts
    localparam logic [2:0] SAW_LAST_STAGE = 3'd7;

    // configuration register indexes
    localparam logic CFG_A0_BIT = 1'b0;
    localparam logic CFG_A1_BIT = 1'b1;
    localparam logic [2:0] CFG_A0_RESET = 3'd0;
    localparam logic [2:0] CFG_A1_RESET = 3'd1;

    typedef struct packed {
        logic        mode;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } t_item;

    typedef struct packed {
        logic       irq_request;
        logic [5:0] audio_mix;
    } t_result;

endpackage

FILE: rtl/pss_core.sv
// ----------------------------------------------------------------------------
// pss_core: channel and irq state of the pulse/sawtooth synth
// Holds all synth state; applies one item per enabled cycle and presents
// the result seen after that item.
// ----------------------------------------------------------------------------
module pss_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  pss_pkg::t_item  i_item,
    input  logic [2:0]      i_a0_bit,
    input  logic [2:0]      i_a1_bit,
    output pss_pkg::t_result o_result
);
    import pss_pkg::*;

    // pulse channel state
    logic        r_pu_duty_mode [2];
    logic [2:0]  r_pu_duty      [2];
    logic [3:0]  r_pu_volume    [2];
    logic        r_pu_enable    [2];
    logic [11:0] r_pu_period    [2];
    logic [11:0] r_pu_div       [2];
    logic [3:0]  r_pu_step      [2];
    logic [3:0]  r_pu_level     [2];
    logic        n_pu_duty_mode [2];
    logic [2:0]  n_pu_duty      [2];
    logic [3:0]  n_pu_volume    [2];
    logic        n_pu_enable    [2];
    logic [11:0] n_pu_period    [2];
    logic [11:0] n_pu_div       [2];
    logic [3:0]  n_pu_step      [2];
    logic [3:0]  n_pu_level     [2];
    logic [11:0] w_pu_dec       [2];
    logic [3:0]  w_pu_step_inc  [2];

    // sawtooth state
    logic [5:0]  r_saw_rate, n_saw_rate;
    logic        r_saw_enable, n_saw_enable;
    logic [11:0] r_saw_period, n_saw_period;
    logic [11:0] r_saw_div, n_saw_div;
    logic        r_saw_phase, n_saw_phase;
    logic [2:0]  r_saw_stage, n_saw_stage;
    logic [7:0]  r_saw_acc, n_saw_acc;
    logic [4:0]  r_saw_level, n_saw_level;
    logic [11:0] w_saw_dec;
    logic [2:0]  w_saw_stage_inc;

    // irq state
    logic [7:0]        r_irq_reload, n_irq_reload;
    logic              r_irq_cycle_mode, n_irq_cycle_mode;
    logic              r_irq_enabled, n_irq_enabled;
    logic              r_irq_ack_enable, n_irq_ack_enable;
    logic [7:0]        r_irq_count, n_irq_count;
    logic signed [9:0] r_irq_prescale, n_irq_prescale;
    logic              r_irq_asserted, n_irq_asserted;
    logic signed [9:0] w_pre_sub;
    logic              w_pre_wrap;
    logic              w_cnt_evt;

    // write decode
    logic [7:0] w_addr_lo;
    logic [5:0] w_key;
    logic [7:0] w_d;

    assign w_addr_lo = i_item.bus_address[7:0];
    assign w_key     = {i_item.bus_address[15:12], w_addr_lo[i_a1_bit], w_addr_lo[i_a0_bit]};
    assign w_d       = i_item.write_data;

    // per-channel divider arithmetic
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            w_pu_dec[c]      = r_pu_div[c] - 12'd1;
            w_pu_step_inc[c] = r_pu_step[c] + 4'd1;
        end
    end
    assign w_saw_dec       = r_saw_div - 12'd1;
    assign w_saw_stage_inc = r_saw_stage + 3'd1;
    assign w_pre_sub       = r_irq_prescale - PRESCALE_STEP;
    assign w_pre_wrap      = (w_pre_sub <= 10'sd0);
    assign w_cnt_evt       = r_irq_enabled && (r_irq_cycle_mode || w_pre_wrap);

    // next state for one item
    always_comb begin
        n_pu_duty_mode   = r_pu_duty_mode;
        n_pu_duty        = r_pu_duty;
        n_pu_volume      = r_pu_volume;
        n_pu_enable      = r_pu_enable;
        n_pu_period      = r_pu_period;
        n_pu_div         = r_pu_div;
        n_pu_step        = r_pu_step;
        n_pu_level       = r_pu_level;
        n_saw_rate       = r_saw_rate;
        n_saw_enable     = r_saw_enable;
        n_saw_period     = r_saw_period;
        n_saw_div        = r_saw_div;
        n_saw_phase      = r_saw_phase;
        n_saw_stage      = r_saw_stage;
        n_saw_acc        = r_saw_acc;
        n_saw_level      = r_saw_level;
        n_irq_reload     = r_irq_reload;
        n_irq_cycle_mode = r_irq_cycle_mode;
        n_irq_enabled    = r_irq_enabled;
        n_irq_ack_enable = r_irq_ack_enable;
        n_irq_count      = r_irq_count;
        n_irq_prescale   = r_irq_prescale;
        n_irq_asserted   = r_irq_asserted;

        if (i_en && i_item.mode == MODE_WRITE && i_item.bus_address[15]) begin
            // bus write to a register
            unique case (w_key)
                KEY_P0_CTRL, KEY_P1_CTRL: begin
                    n_pu_volume[w_key[5:2] == 4'ha]    = w_d[3:0];
                    n_pu_duty[w_key[5:2] == 4'ha]      = w_d[6:4];
                    n_pu_duty_mode[w_key[5:2] == 4'ha] = w_d[7];
                end
                KEY_P0_LO, KEY_P1_LO: begin
                    n_pu_period[w_key[5:2] == 4'ha][7:0] = w_d;
                end
                KEY_P0_HI, KEY_P1_HI: begin
                    n_pu_period[w_key[5:2] == 4'ha][11:8] = w_d[3:0];
                    n_pu_enable[w_key[5:2] == 4'ha]       = w_d[7];
                end
                KEY_SAW_RATE: n_saw_rate = w_d[5:0];
                KEY_SAW_LO:   n_saw_period[7:0] = w_d;
                KEY_SAW_HI: begin
                    n_saw_period[11:8] = w_d[3:0];
                    n_saw_enable       = w_d[7];
                end
                KEY_IRQ_LAT: n_irq_reload = w_d;
                KEY_IRQ_CTRL: begin
                    n_irq_ack_enable = w_d[0];
                    n_irq_enabled    = w_d[1];
                    n_irq_cycle_mode = w_d[2];
                    if (w_d[1]) begin
                        n_irq_count    = r_irq_reload;
                        n_irq_prescale = PRESCALE_RELOAD;
                    end
                    n_irq_asserted = 1'b0;
                end
                KEY_IRQ_ACK: begin
                    n_irq_enabled  = r_irq_ack_enable;
                    n_irq_asserted = 1'b0;
                end
                default: ;
            endcase
        end else if (i_en && i_item.mode == MODE_TICK) begin
            // irq prescaler and counter
            if (r_irq_enabled && !r_irq_cycle_mode) begin
                n_irq_prescale = w_pre_wrap ? (w_pre_sub + PRESCALE_RELOAD) : w_pre_sub;
            end
            if (w_cnt_evt) begin
                if (r_irq_count == COUNT_MAX) begin
                    n_irq_count    = r_irq_reload;
                    n_irq_asserted = 1'b1;
                end else begin
                    n_irq_count = r_irq_count + 8'd1;
                end
            end

            // pulse channels
            for (int c = 0; c < 2; c++) begin
                if (w_pu_dec[c] == 12'd0) begin
                    n_pu_div[c]  = r_pu_period[c] + 12'd1;
                    n_pu_step[c] = w_pu_step_inc[c];
                    n_pu_level[c] = (r_pu_duty_mode[c] || w_pu_step_inc[c] > {1'b0, r_pu_duty[c]})
                                    ? r_pu_volume[c] : 4'd0;
                end else begin
                    n_pu_div[c] = w_pu_dec[c];
                end
                if (!r_pu_enable[c]) begin
                    n_pu_level[c] = 4'd0;
                end
            end

            // sawtooth: accumulate every second divider wrap
            if (w_saw_dec == 12'd0) begin
                n_saw_div   = r_saw_period + 12'd1;
                n_saw_phase = ~r_saw_phase;
                if (r_saw_phase) begin
                    if (w_saw_stage_inc == SAW_LAST_STAGE) begin
                        n_saw_stage = 3'd0;
                        n_saw_acc   = 8'd0;
                    end else begin
                        n_saw_stage = w_saw_stage_inc;
                        n_saw_acc   = r_saw_acc + {2'b00, r_saw_rate};
                    end
                end
            end else begin
                n_saw_div = w_saw_dec;
            end
            n_saw_level = r_saw_enable ? n_saw_acc[7:3] : 5'd0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 2; c++) begin
                r_pu_duty_mode[c] <= 1'b0;
                r_pu_duty[c]      <= 3'd0;
                r_pu_volume[c]    <= 4'd0;
                r_pu_enable[c]    <= 1'b0;
                r_pu_period[c]    <= 12'd0;
                r_pu_div[c]       <= 12'd1;
                r_pu_step[c]      <= 4'd0;
                r_pu_level[c]     <= 4'd0;
            end
            r_saw_rate       <= 6'd0;
            r_saw_enable     <= 1'b0;
            r_saw_period     <= 12'd0;
            r_saw_div        <= 12'd1;
            r_saw_phase      <= 1'b0;
            r_saw_stage      <= 3'd0;
            r_saw_acc        <= 8'd0;
            r_saw_level      <= 5'd0;
            r_irq_reload     <= 8'd0;
            r_irq_cycle_mode <= 1'b0;
            r_irq_enabled    <= 1'b0;
            r_irq_ack_enable <= 1'b0;
            r_irq_count      <= 8'd0;
            r_irq_prescale   <= 10'sd0;
            r_irq_asserted   <= 1'b0;
        end else begin
            r_pu_duty_mode   <= n_pu_duty_mode;
            r_pu_duty        <= n_pu_duty;
            r_pu_volume      <= n_pu_volume;
            r_pu_enable      <= n_pu_enable;
            r_pu_period      <= n_pu_period;
            r_pu_div         <= n_pu_div;
            r_pu_step        <= n_pu_step;
            r_pu_level       <= n_pu_level;
            r_saw_rate       <= n_saw_rate;
            r_saw_enable     <= n_saw_enable;
            r_saw_period     <= n_saw_period;
            r_saw_div        <= n_saw_div;
            r_saw_phase      <= n_saw_phase;
            r_saw_stage      <= n_saw_stage;
            r_saw_acc        <= n_saw_acc;
            r_saw_level      <= n_saw_level;
            r_irq_reload     <= n_irq_reload;
            r_irq_cycle_mode <= n_irq_cycle_mode;
            r_irq_enabled    <= n_irq_enabled;
            r_irq_ack_enable <= n_irq_ack_enable;
            r_irq_count      <= n_irq_count;
            r_irq_prescale   <= n_irq_prescale;
            r_irq_asserted   <= n_irq_asserted;
        end
    end

    // result after this item
    assign o_result.irq_request = n_irq_asserted;
    assign o_result.audio_mix   = {2'b00, n_pu_level[0]} + {2'b00, n_pu_level[1]}
                                + {1'b0, n_saw_level};

endmodule

FILE: rtl/pulse_saw_synth_cycle_irq.sv
// ----------------------------------------------------------------------------
// pulse_saw_synth_cycle_irq: two pulse channels, a sawtooth and a cycle irq
// Input register, combinational next-state update and output register.
// ----------------------------------------------------------------------------
// Usage
// Input channel: i_in_valid / o_in_stall carry one item (i_mode, i_bus_address,
// i_write_data). A write item (mode 0) at 0x8000 or above updates channel or
// irq registers; a tick item (mode 1) advances the irq counter and the three
// channels by one cpu cycle. Every item gives exactly one result item on
// o_out_valid / i_out_stall: the irq line and the channel level sum (0..61).
// Path: an accepted item waits in the input register; its result is loaded into
// the output register when the item moves on, which a receiver stall can hold.
// Throughput: one item per cycle while the receiver does not stall; the whole
// state update of each item is done between the input and output registers.
// Stall: while the receiver stalls a valid output item, that item holds and the
// input register keeps its item; o_in_stall rises only when the input register
// is full and cannot move on. APB writes set the address select bit positions
// (register 0 at address 0, register 1 at address 4); the user must make them
// only while the block is idle, which the block itself does not enforce.
// Reset: synchronous, active low; clears all channel and irq state, empties
// both registers and sets the select bits to 0 and 1.
// ----------------------------------------------------------------------------
module pulse_saw_synth_cycle_irq (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [15:0] i_bus_address,
    input  logic [7:0]  i_write_data,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_irq_request,
    output logic [5:0]  o_audio_mix,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pss_pkg::*;

    logic [2:0] r_a0_bit;
    logic [2:0] r_a1_bit;
    logic       w_cfg_wr;

    logic       r_a_vld;
    t_item      r_a_item;
    logic       w_in_acc;
    logic       w_adv;
    logic       r_o_vld;
    t_result    r_o_res;
    t_result    w_res;

    // configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = {29'd0, (paddr[2] == CFG_A1_BIT) ? r_a1_bit : r_a0_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a0_bit <= CFG_A0_RESET;
            r_a1_bit <= CFG_A1_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == CFG_A0_BIT) begin
                r_a0_bit <= pwdata[2:0];
            end else begin
                r_a1_bit <= pwdata[2:0];
            end
        end
    end

    // handshake
    assign w_adv      = r_a_vld && (!r_o_vld || !i_out_stall);
    assign o_in_stall = r_a_vld && !w_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_a_vld <= 1'b1;
        end else if (w_adv) begin
            r_a_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a_item.mode        <= i_mode;
            r_a_item.bus_address <= i_bus_address;
            r_a_item.write_data  <= i_write_data;
        end
    end

    // synth state
    pss_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_item   (r_a_item),
        .i_a0_bit (r_a0_bit),
        .i_a1_bit (r_a1_bit),
        .o_result (w_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_adv) begin
            r_o_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_res <= w_res;
        end
    end

    assign o_out_valid   = r_o_vld;
    assign o_irq_request = r_o_res.irq_request;
    assign o_audio_mix   = r_o_res.audio_mix;

    // checks
    a_mix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_audio_mix <= 6'd61))
        else $error("audio mix above channel maximum");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_a_vld && r_o_vld && i_out_stall))
        else $error("input stalled without a blocked item");

    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_out_valid)
        else $error("processed item did not reach the output register");

endmodule

FILE: dv/pulse_saw_synth_cycle_irq_test.sv
// ----------------------------------------------------------------------------
// pulse_saw_synth_cycle_irq_test: self-checking bench for the synth block
// Feeds bus writes and clock ticks through the valid/stall input channel,
// predicts the irq line and channel mix of every item and checks each result
// in order. Runs several select-line settings written over the apb port.
// ----------------------------------------------------------------------------
module pulse_saw_synth_cycle_irq_test;
    import pss_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1850;
    localparam int N_PHASES     = 6;
    localparam int TAIL_CYCLES  = 4;

    localparam logic [2:0]  A0_ADDR        = {CFG_A0_BIT, 2'b00};
    localparam logic [2:0]  A1_ADDR        = {CFG_A1_BIT, 2'b00};
    localparam logic [15:0] REG_SPACE_BASE = 16'h8000;
    localparam logic [1:0]  SEL_UNUSED     = 2'd3;
    localparam logic [3:0]  NIB_BANKING    = 4'h8;
    localparam logic [3:0]  NIB_MAP_LO     = 4'hc;
    localparam logic [3:0]  NIB_MAP_HI     = 4'he;

    // per-phase select lines and idle percentage, phase 0 in the low slot
    localparam logic [5:0][2:0] PHASE_A0   = {3'd0, 3'd5, 3'd3, 3'd0, 3'd7, 3'd0};
    localparam logic [5:0][2:0] PHASE_A1   = {3'd1, 3'd2, 3'd3, 3'd7, 3'd0, 3'd1};
    localparam logic [5:0][7:0] PHASE_IDLE = {8'd0, 8'd25, 8'd0, 8'd35, 8'd15, 8'd25};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_mode = MODE_WRITE;
    logic [15:0] i_bus_address = '0;
    logic [7:0]  i_write_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_irq_request;
    logic [5:0]  o_audio_mix;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    pulse_saw_synth_cycle_irq u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_bus_address (i_bus_address),
        .i_write_data  (i_write_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_irq_request (o_irq_request),
        .o_audio_mix   (o_audio_mix),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // predicted synth state: select lines, pulses, sawtooth, irq counter
    logic [2:0]        sel0_bit, sel1_bit;
    logic              pl_duty_mode [2];
    logic [2:0]        pl_duty      [2];
    logic [3:0]        pl_vol       [2];
    logic              pl_on        [2];
    logic [11:0]       pl_period    [2];
    logic [11:0]       pl_div       [2];
    logic [3:0]        pl_step      [2];
    logic [3:0]        pl_level     [2];
    logic [5:0]        sw_rate;
    logic              sw_on;
    logic [11:0]       sw_period, sw_div;
    logic              sw_phase;
    logic [2:0]        sw_stage;
    logic [7:0]        sw_acc;
    logic [4:0]        sw_level;
    logic [7:0]        irq_latch, irq_cnt;
    logic              irq_cyc, irq_en, irq_ack_en, irq_line;
    logic signed [9:0] irq_presc;

    t_item   bus_tick_queue [$];
    t_result synth_out_due  [$];
    t_item   cur_item;

    int idle_pct = 0;
    int send_gap = 0;
    int stall_left = 0;
    int failures = 0;
    int cycle_count = 0;
    int writes_accepted = 0;
    int ticks_accepted = 0;
    int results_checked = 0;
    int irq_results = 0;
    int peak_mix = 0;

    function automatic void clear_model();
        sel0_bit = CFG_A0_RESET;
        sel1_bit = CFG_A1_RESET;
        for (int c = 0; c < 2; c++) begin
            pl_duty_mode[c] = 1'b0;
            pl_duty[c]      = '0;
            pl_vol[c]       = '0;
            pl_on[c]        = 1'b0;
            pl_period[c]    = '0;
            pl_div[c]       = 12'd1;
            pl_step[c]      = '0;
            pl_level[c]     = '0;
        end
        sw_rate    = '0;
        sw_on      = 1'b0;
        sw_period  = '0;
        sw_div     = 12'd1;
        sw_phase   = 1'b0;
        sw_stage   = '0;
        sw_acc     = '0;
        sw_level   = '0;
        irq_latch  = '0;
        irq_cnt    = '0;
        irq_cyc    = 1'b0;
        irq_en     = 1'b0;
        irq_ack_en = 1'b0;
        irq_line   = 1'b0;
        irq_presc  = '0;
    endfunction

    // one count event of the irq counter, overflow reloads and raises the line
    function automatic void bump_irq_count();
        if (irq_cnt == COUNT_MAX) begin
            irq_cnt  = irq_latch;
            irq_line = 1'b1;
        end else begin
            irq_cnt = irq_cnt + 8'd1;
        end
    endfunction

    // one cpu cycle of a pulse channel
    function automatic void advance_pulse(int c);
        pl_div[c] = pl_div[c] - 12'd1;
        if (pl_div[c] == 12'd0) begin
            pl_div[c]   = pl_period[c] + 12'd1;
            pl_step[c]  = pl_step[c] + 4'd1;
            pl_level[c] = (pl_duty_mode[c] || pl_step[c] > {1'b0, pl_duty[c]}) ?
                          pl_vol[c] : 4'd0;
        end
        if (!pl_on[c])
            pl_level[c] = 4'd0;
    endfunction

    // expected result of one item, state updated in place
    function automatic t_result synth_step(t_item it);
        t_result    r;
        logic [5:0] key;
        logic [7:0] d;
        int         c;
        if (it.mode == MODE_WRITE) begin
            if (it.bus_address >= REG_SPACE_BASE) begin
                d   = it.write_data;
                key = {it.bus_address[15:12], it.bus_address[sel1_bit],
                       it.bus_address[sel0_bit]};
                c   = (key[5:2] == KEY_P1_CTRL[5:2]) ? 1 : 0;
                case (key)
                    KEY_P0_CTRL, KEY_P1_CTRL: begin
                        pl_vol[c]       = d[3:0];
                        pl_duty[c]      = d[6:4];
                        pl_duty_mode[c] = d[7];
                    end
                    KEY_P0_LO, KEY_P1_LO: pl_period[c][7:0] = d;
                    KEY_P0_HI, KEY_P1_HI: begin
                        pl_period[c][11:8] = d[3:0];
                        pl_on[c]           = d[7];
                    end
                    KEY_SAW_RATE: sw_rate = d[5:0];
                    KEY_SAW_LO:   sw_period[7:0] = d;
                    KEY_SAW_HI: begin
                        sw_period[11:8] = d[3:0];
                        sw_on           = d[7];
                    end
                    KEY_IRQ_LAT: irq_latch = d;
                    KEY_IRQ_CTRL: begin
                        irq_ack_en = d[0];
                        irq_en     = d[1];
                        irq_cyc    = d[2];
                        if (irq_en) begin
                            irq_cnt   = irq_latch;
                            irq_presc = PRESCALE_RELOAD;
                        end
                        irq_line = 1'b0;
                    end
                    KEY_IRQ_ACK: begin
                        irq_en   = irq_ack_en;
                        irq_line = 1'b0;
                    end
                    default: ;
                endcase
            end
        end else begin
            // irq counter first, then the three channels
            if (irq_en) begin
                if (!irq_cyc) begin
                    irq_presc = irq_presc - PRESCALE_STEP;
                    if (irq_presc <= 0) begin
                        irq_presc = irq_presc + PRESCALE_RELOAD;
                        bump_irq_count();
                    end
                end else begin
                    bump_irq_count();
                end
            end
            advance_pulse(0);
            advance_pulse(1);
            sw_div = sw_div - 12'd1;
            if (sw_div == 12'd0) begin
                sw_div   = sw_period + 12'd1;
                sw_phase = ~sw_phase;
                if (!sw_phase) begin
                    sw_acc   = sw_acc + {2'b00, sw_rate};
                    sw_stage = sw_stage + 3'd1;
                    if (sw_stage == SAW_LAST_STAGE) begin
                        sw_stage = '0;
                        sw_acc   = '0;
                    end
                end
            end
            sw_level = sw_on ? sw_acc[7:3] : 5'd0;
        end
        r.irq_request = irq_line;
        r.audio_mix   = {2'b00, pl_level[0]} + {2'b00, pl_level[1]} + {1'b0, sw_level};
        return r;
    endfunction

    // stimulus helpers
    function automatic logic [15:0] key_address(logic [5:0] key);
        logic [15:0] a;
        a = {key[5:2], 12'($urandom)};
        a[sel0_bit] = key[0];
        a[sel1_bit] = key[1];
        return a;
    endfunction

    function automatic void push_write(logic [15:0] addr, logic [7:0] data);
        t_item it;
        it.mode        = MODE_WRITE;
        it.bus_address = addr;
        it.write_data  = data;
        bus_tick_queue.push_back(it);
    endfunction

    // tick items carry random address and data, which the block ignores
    function automatic void push_ticks(int n);
        t_item it;
        for (int k = 0; k < n; k++) begin
            it.mode        = MODE_TICK;
            it.bus_address = 16'($urandom);
            it.write_data  = 8'($urandom);
            bus_tick_queue.push_back(it);
        end
    endfunction

    // program one channel with a short period, then let it run
    function automatic int queue_channel_program();
        int         ch;
        int         n;
        logic [5:0] k_ctrl, k_lo, k_hi;
        logic [7:0] hi;
        ch     = $urandom_range(2);
        k_ctrl = (ch == 0) ? KEY_P0_CTRL : (ch == 1) ? KEY_P1_CTRL : KEY_SAW_RATE;
        k_lo   = (ch == 0) ? KEY_P0_LO   : (ch == 1) ? KEY_P1_LO   : KEY_SAW_LO;
        k_hi   = (ch == 0) ? KEY_P0_HI   : (ch == 1) ? KEY_P1_HI   : KEY_SAW_HI;
        n      = 2;
        if ($urandom_range(3) != 0) begin
            push_write(key_address(k_ctrl), 8'($urandom));
            n++;
        end
        push_write(key_address(k_lo), ($urandom_range(9) == 0) ?
                   8'($urandom) : 8'($urandom_range(15)));
        // high period nibble kept clear so dividers never run for thousands of ticks
        hi      = 8'($urandom);
        hi[3:0] = 4'd0;
        hi[7]   = ($urandom_range(9) != 0);
        push_write(key_address(k_hi), hi);
        ch = $urandom_range(4, 40);
        push_ticks(ch);
        return n + ch;
    endfunction

    // set the latch and start the counter, mostly near overflow
    function automatic int queue_irq_program();
        logic [7:0] ctrl;
        int         n;
        push_write(key_address(KEY_IRQ_LAT), $urandom_range(1) ?
                   8'($urandom_range(8'hf0, 8'hff)) : 8'($urandom));
        ctrl    = 8'($urandom);
        ctrl[1] = ($urandom_range(4) != 0);
        ctrl[2] = ($urandom_range(3) != 0);
        push_write(key_address(KEY_IRQ_CTRL), ctrl);
        n = $urandom_range(10, 60);
        push_ticks(n);
        return n + 2;
    endfunction

    function automatic void queue_random(int target);
        int made;
        int pick;
        int n;
        made = 0;
        // prescaler run long enough for one count event at overflow
        push_write(key_address(KEY_IRQ_LAT), COUNT_MAX);
        push_write(key_address(KEY_IRQ_CTRL), 8'h02);
        n = $urandom_range(115, 130);
        push_ticks(n);
        made += n + 2;
        while (made < target) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                made += queue_channel_program();
            end else if (pick < 55) begin
                made += queue_irq_program();
            end else if (pick < 63) begin
                push_write(key_address(KEY_IRQ_ACK), 8'($urandom));
                n = $urandom_range(1, 8);
                push_ticks(n);
                made += n + 1;
            end else if (pick < 83) begin
                n = $urandom_range(1, 30);
                push_ticks(n);
                made += n;
            end else if (pick < 95) begin
                // raw bus noise over the whole address space
                push_write(16'($urandom), 8'($urandom));
                made += 1;
            end else begin
                // writes to unused select codes or unused address ranges
                if ($urandom_range(1) != 0)
                    push_write(key_address({KEY_P0_CTRL[5:2] + 4'($urandom_range(2)),
                                            SEL_UNUSED}), 8'($urandom));
                else
                    push_write(key_address({($urandom_range(3) == 0) ? NIB_BANKING :
                                            4'($urandom_range(NIB_MAP_LO, NIB_MAP_HI)),
                                            2'($urandom)}), 8'($urandom));
                n = $urandom_range(1, 6);
                push_ticks(n);
                made += n + 1;
            end
        end
    endfunction

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_all_results();
        do @(negedge i_clk);
        while (bus_tick_queue.size() > 0 || i_in_valid || synth_out_due.size() > 0);
    endtask

    // item driver: predict on acceptance, then present the next item or a gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                synth_out_due.push_back(synth_step(cur_item));
                if (cur_item.mode == MODE_WRITE)
                    writes_accepted++;
                else
                    ticks_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (bus_tick_queue.size() > 0) begin
                    cur_item      = bus_tick_queue.pop_front();
                    i_mode        <= cur_item.mode;
                    i_bus_address <= cur_item.bus_address;
                    i_write_data  <= cur_item.write_data;
                    i_in_valid    <= 1'b1;
                    if (idle_pct > 0 && $urandom_range(99) < idle_pct)
                        send_gap = $urandom_range(1, 3);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall bursts, started at random at the phase's idle percentage
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            stall_left = $urandom_range(2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // result monitor: compare with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (synth_out_due.size() == 0) begin
                $error("result with no item outstanding: irq_request %0b audio_mix %0d",
                       o_irq_request, o_audio_mix);
                failures++;
            end else begin
                want = synth_out_due.pop_front();
                if (o_irq_request !== want.irq_request) begin
                    $error("irq_request: expected %0b, got %0b",
                           want.irq_request, o_irq_request);
                    failures++;
                end
                if (o_audio_mix !== want.audio_mix) begin
                    $error("audio_mix: expected %0d, got %0d", want.audio_mix, o_audio_mix);
                    failures++;
                end
                results_checked++;
                if (o_irq_request === 1'b1)
                    irq_results++;
                if (int'(o_audio_mix) > peak_mix)
                    peak_mix = int'(o_audio_mix);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, synth_out_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // sequencing: reset, directed items, then random phases per select setting
    initial begin
        clear_model();
        idle_pct = int'(PHASE_IDLE[0]);
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // writes below the register space are ignored
        push_write(16'h0000, 8'h00);
        push_write(16'h7fff, 8'hff);
        // pulse 0 always high at full volume, period 0 so it steps every tick
        push_write(key_address(KEY_P0_CTRL), 8'h8f);
        push_write(key_address(KEY_P0_LO), 8'h00);
        push_write(key_address(KEY_P0_HI), 8'h80);
        // pulse 1 at the largest duty field value, the narrowest high pulse
        push_write(key_address(KEY_P1_CTRL), 8'h7f);
        push_write(key_address(KEY_P1_LO), 8'h01);
        push_write(key_address(KEY_P1_HI), 8'h80);
        // sawtooth at the largest rate
        push_write(key_address(KEY_SAW_RATE), 8'h3f);
        push_write(key_address(KEY_SAW_LO), 8'h00);
        push_write(key_address(KEY_SAW_HI), 8'h80);
        // cycle-mode counter loaded at overflow, line rises on the first tick
        push_write(key_address(KEY_IRQ_LAT), COUNT_MAX);
        push_write(key_address(KEY_IRQ_CTRL), 8'h07);
        push_ticks(3);
        push_write(key_address(KEY_IRQ_ACK), 8'h00);
        // unused select code and banking range
        push_write(16'hffff, 8'hff);
        push_write(key_address({NIB_BANKING, 2'd0}), 8'h55);
        push_ticks(4);
        // disabled channel forced to zero, counter stopped
        push_write(key_address(KEY_P1_HI), 8'h00);
        push_write(key_address(KEY_IRQ_CTRL), 8'h00);
        push_ticks(3);

        for (int phase = 0; phase < N_PHASES; phase++) begin
            if (phase > 0) begin
                apb_write(A0_ADDR, {29'd0, PHASE_A0[phase]});
                sel0_bit = PHASE_A0[phase];
                apb_write(A1_ADDR, {29'd0, PHASE_A1[phase]});
                sel1_bit = PHASE_A1[phase];
                @(negedge i_clk);
            end
            idle_pct = int'(PHASE_IDLE[phase]);
            queue_random(RANDOM_ITEMS / N_PHASES);
            if (phase == N_PHASES - 1) begin
                // longest periods: divider reloads to zero and wraps on the next tick
                push_write(key_address(KEY_P1_LO), 8'hff);
                push_write(key_address(KEY_P1_HI), 8'h8f);
                push_write(key_address(KEY_SAW_LO), 8'hff);
                push_write(key_address(KEY_SAW_HI), 8'h8f);
                push_ticks(12);
            end
            wait_all_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (synth_out_due.size() != 0) begin
            $error("%0d predicted results never arrived", synth_out_due.size());
            failures++;
        end
        $display("covered %0d bus writes and %0d ticks over %0d select-line settings",
                 writes_accepted, ticks_accepted, N_PHASES);
        $display("checked %0d results, %0d with the irq line high, peak mix %0d",
                 results_checked, irq_results, peak_mix);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
